// ===== src/mrpt_pkg.sv =====
// package for the miller-rabin prime test block
// holds the arithmetic width and the number type; no dependencies
package mrpt_pkg;
	localparam int NumWidth = 32;
	localparam int CntWidth = $clog2(NumWidth + 1);
	typedef logic [NumWidth-1:0] num_t;
	typedef logic [CntWidth-1:0] cnt_t;
endpackage

// ===== src/mrpt_mulmod.sv =====
// iterative modular multiplier: p = x * y mod m, one bit of y per cycle
// depends on mrpt_pkg
module mrpt_mulmod import mrpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  num_t x,
	input  num_t y,
	input  num_t m,
	output logic done,
	output num_t p
);
	num_t x_q, y_q, m_q, acc_q;
	cnt_t cnt_q;
	logic busy_q;
	logic [NumWidth:0] dbl, dred, add;
	num_t accd;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		accd = dred[NumWidth-1:0];
		add = {1'b0, accd} + {1'b0, x_q};
		if (y_q[NumWidth-1]) begin
			if (add >= {1'b0, m_q}) add = add - {1'b0, m_q};
		end else begin
			add = {1'b0, accd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntWidth'(NumWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			m_q <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= add[NumWidth-1:0];
			y_q <= {y_q[NumWidth-2:0], 1'b0};
		end
	end
	assign p = acc_q;
endmodule

// ===== src/miller_rabin_prime_test.sv =====
// top level of the miller-rabin prime test: sequencer around one shared
// modular multiplier; depends on mrpt_pkg and mrpt_mulmod
// One base is judged per input word. The candidate minus one is split into
// r times 2^s by one shift a cycle, the base is reduced by a shift-subtract
// remainder, then a^r mod n is formed by square-and-multiply and up to s-1
// further squarings follow, each a pass through the shared multiplier. A
// candidate below three is judged directly, without the other steps. in_ready
// is low while a base is worked; a result word is given only for a word marked
// last_base and is held in an output register until taken, and a later last
// word waits in its final step while that register is still full.
module miller_rabin_prime_test import mrpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] candidate,
	input  logic [31:0] base,
	input  logic last_base,
	output logic out_valid,
	input  logic out_ready,
	output logic probable_prime
);
	typedef enum logic [3:0] {
		IDLE, SPLIT, RED, POW, POWW, POWS, POWSW, SQ, SQW, DONE
	} state_t;

	state_t state_q;
	num_t n_q, a_q, r_q, y_q, sq_q, nm1, rem_q;
	cnt_t s_q, cnt_q;
	logic last_q, pass_q, all_q;
	logic mstart;
	num_t mx, my, mp;
	logic mdone;
	logic [NumWidth:0] rsh;
	logic fin_pass;
	logic out_take;

	assign nm1 = n_q - 1'b1;
	assign in_ready = (state_q == IDLE);
	assign out_take = out_valid && out_ready;

	always_comb begin
		mstart = 1'b0;
		mx = y_q;
		my = sq_q;
		unique case (state_q)
			POW: begin mstart = r_q[0]; mx = y_q; my = sq_q; end
			POWS: begin mstart = 1'b1; mx = sq_q; my = sq_q; end
			SQ: begin mstart = !(cnt_q >= s_q || y_q == nm1); mx = y_q; my = y_q; end
			default: ;
		endcase
		rsh = {rem_q, a_q[NumWidth-1]};
	end

	mrpt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart),
		.x(mx), .y(my), .m(n_q), .done(mdone), .p(mp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
			all_q <= 1'b1;
			probable_prime <= 1'b0;
		end else begin
			if (out_take && !(state_q == DONE && last_q)) out_valid <= 1'b0;
			unique case (state_q)
				IDLE: if (in_valid && in_ready) begin
					n_q <= candidate;
					a_q <= base;
					last_q <= last_base;
					r_q <= candidate - 1'b1;
					s_q <= '0;
					rem_q <= '0;
					cnt_q <= CntWidth'(NumWidth);
					if (candidate < 32'd2) begin
						pass_q <= 1'b0; state_q <= DONE;
					end else if (candidate == 32'd2) begin
						pass_q <= 1'b1; state_q <= DONE;
					end else state_q <= SPLIT;
				end
				SPLIT: if (!r_q[0] && r_q != '0) begin
					r_q <= r_q >> 1;
					s_q <= s_q + 1'b1;
				end else state_q <= RED;
				RED: begin
					if (cnt_q == '0) begin
						sq_q <= rem_q;
						y_q <= NumWidth'(1);
						state_q <= POW;
					end else begin
						rem_q <= (rsh >= {1'b0, n_q}) ? NumWidth'(rsh - {1'b0, n_q})
							: rsh[NumWidth-1:0];
						a_q <= a_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				POW: if (r_q == '0) begin
					cnt_q <= CntWidth'(1);
					if (y_q == NumWidth'(1) || y_q == nm1) begin
						pass_q <= 1'b1; state_q <= DONE;
					end else state_q <= SQ;
				end else state_q <= r_q[0] ? POWW : POWS;
				POWW: if (mdone) begin y_q <= mp; state_q <= POWS; end
				POWS: state_q <= POWSW;
				POWSW: if (mdone) begin
					sq_q <= mp; r_q <= r_q >> 1; state_q <= POW;
				end
				SQ: if (cnt_q >= s_q || y_q == nm1) begin
					pass_q <= (y_q == nm1); state_q <= DONE;
				end else state_q <= SQW;
				SQW: if (mdone) begin
					y_q <= mp;
					cnt_q <= cnt_q + 1'b1;
					if (mp == NumWidth'(1)) begin
						pass_q <= 1'b0; state_q <= DONE;
					end else state_q <= SQ;
				end
				DONE: begin
					if (last_q) begin
						if (!out_valid || out_take) begin
							state_q <= IDLE;
							out_valid <= 1'b1;
							probable_prime <= all_q & pass_q;
							all_q <= 1'b1;
						end
					end else begin
						state_q <= IDLE;
						all_q <= all_q & pass_q;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign fin_pass = pass_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == IDLE) else $error("ready outside idle");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == DONE && $past(last_q))
		else $error("result without last word");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> state_q == POWW || state_q == POWSW || state_q == SQW)
		else $error("stray multiplier done");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> all_q) else $error("verdict not rearmed");
	a_prime_fail: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid) && !$past(fin_pass)) |-> !probable_prime)
		else $error("failed base reported prime");
endmodule

// ===== test/tb.sv =====
// testbench for miller_rabin_prime_test: random and directed witness words,
// self-contained predictor and in-order result checking; depends on mrpt_pkg
module tb;
	import mrpt_pkg::*;

	typedef struct packed {
		logic [31:0] cand;
		logic [31:0] wit;
		logic        last;
	} word_t;

	localparam int WatchLimit = 200000;
	localparam int HoldLen = 3000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [31:0] candidate = '0;
	logic [31:0] base = '0;
	logic last_base = 0;
	logic out_valid;
	logic out_ready = 0;
	logic probable_prime;

	word_t pending[$];
	bit verdict_q[$];
	bit running_pass = 1;
	int errors = 0;
	int sent = 0;
	int got = 0;
	int idle_cycles = 0;
	bit quiet_end = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	bit in_acc_q = 0;

	miller_rabin_prime_test uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.candidate(candidate), .base(base), .last_base(last_base),
		.out_valid(out_valid), .out_ready(out_ready),
		.probable_prime(probable_prime)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] p;
		p = x * y;
		return 64'(p % m);
	endfunction

	function automatic bit witness_passes(logic [31:0] n32, logic [31:0] a32);
		logic [63:0] n, r, y, nm1, sq, e;
		int s;
		n = {32'd0, n32};
		if (n < 2) return 0;
		if (n == 2) return 1;
		nm1 = n - 1;
		r = nm1;
		s = 0;
		while (r[0] == 0 && r != 0) begin
			r = r >> 1;
			s++;
		end
		y = 1;
		sq = {32'd0, a32} % n;
		e = r;
		while (e != 0) begin
			if (e[0]) y = mulmod(y, sq, n);
			sq = mulmod(sq, sq, n);
			e = e >> 1;
		end
		if (y == 1 || y == nm1) return 1;
		for (int j = 1; j + 1 <= s && y != nm1; j++) begin
			y = mulmod(y, y, n);
			if (y == 1) return 0;
		end
		return y == nm1;
	endfunction

	task automatic queue_word(logic [31:0] n, logic [31:0] a, bit l);
		word_t w;
		w.cand = n;
		w.wit = a;
		w.last = l;
		pending.push_back(w);
	endtask

	// driver
	int tx_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc_q) begin
				sent++;
				if (!quiet_end && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 16);
			end
			if (!in_valid || in_acc_q) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 0;
				end else if (pending.size() > 0) begin
					word_t w;
					w = pending.pop_front();
					candidate <= w.cand;
					base <= w.wit;
					last_base <= w.last;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stall
	int rx_gap = 0;
	int hold_count = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				out_ready <= 0;
				hold_count++;
				if (hold_count >= HoldLen) hold_done = 1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (!quiet_end && $urandom_range(0, 3) == 0) rx_gap = $urandom_range(1, 16);
			end
		end
	end

	// predictor on accepted input words, monitor on results
	always @(posedge clk) begin
		in_acc_q = in_valid && in_ready;
		if (in_valid && in_ready) begin
			if (!witness_passes(candidate, base)) running_pass = 0;
			if (last_base) begin
				verdict_q.push_back(running_pass);
				running_pass = 1;
			end
		end
		if (out_valid && out_ready) begin
			got++;
			if (verdict_q.size() == 0) begin
				$error("unexpected word: probable_prime=%0d", probable_prime);
				errors++;
			end else begin
				bit exp_pp;
				exp_pp = verdict_q.pop_front();
				if (probable_prime !== exp_pp) begin
					$error("probable_prime: expected %0d, actual %0d", exp_pp, probable_prime);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_odd(int bits);
		logic [31:0] v;
		v = $urandom();
		if (bits < 32) v = v & ((32'd1 << bits) - 1);
		v[bits-1] = 1;
		v[0] = 1;
		if (v < 3) v = 3;
		return v;
	endfunction

	initial begin
		logic [31:0] n, a;
		int k, nb;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		queue_word(32'd0, 32'd2, 1);
		queue_word(32'd1, 32'd5, 1);
		queue_word(32'd2, 32'd3, 1);
		queue_word(32'd3, 32'd2, 1);
		queue_word(32'd561, 32'd2, 0);
		queue_word(32'd561, 32'd5, 1);
		queue_word(32'd100, 32'd99, 1);
		queue_word(32'd97, 32'd97, 1);
		queue_word(32'd97, 32'd194, 1);
		queue_word(32'd97, 32'd1, 1);
		queue_word(32'd97, 32'd96, 1);
		queue_word(32'hFFFFFFFB, 32'd2, 0);
		queue_word(32'hFFFFFFFB, 32'hFFFFFFFF, 1);
		queue_word(32'hFFFFFFFF, 32'hFFFFFFFE, 1);
		queue_word(32'hFFFFFFFF, 32'h00000000, 1);
		queue_word(32'd2047, 32'd2, 1);
		queue_word(32'd13, 32'd5, 0);
		queue_word(32'd15, 32'd2, 1);
		queue_word(32'h80000000, 32'h55555555, 1);
		queue_word(32'd7, 32'hAAAAAAAA, 0);
		queue_word(32'd7, 32'd6, 1);
		wait (pending.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);
		repeat (50) @(negedge clk);

		// long receiver hold while the sender keeps offering
		hold_req = 1;
		for (k = 0; k < 6; k++) queue_word(rand_odd(8), $urandom_range(2, 200), 1);
		wait (hold_done);
		hold_req = 0;

		// random: mostly well-formed multi-base tests, small sizes mostly
		k = 0;
		while (k < 110) begin
			case ($urandom_range(0, 9))
				0: n = $urandom();
				1: n = rand_odd(32);
				default: n = rand_odd($urandom_range(3, 16));
			endcase
			nb = $urandom_range(1, 4);
			for (int b = 0; b < nb; b++) begin
				if ($urandom_range(0, 7) == 0) a = $urandom();
				else a = (n > 3) ? $urandom_range(2, n - 2) : 32'd2;
				queue_word(n, a, b == nb - 1);
				k++;
			end
		end
		wait (pending.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);

		// final part with no idling
		quiet_end = 1;
		for (k = 0; k < 10; k++)
			queue_word(rand_odd(12), $urandom(), 1'($urandom_range(0, 1)) | (k == 9));
		wait (pending.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);
		repeat (5000) @(negedge clk);

		$display("ran %0d witness words, checked %0d verdicts", sent, got);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
